// ===== rtl/core/utf8dec_pkg.sv =====
package utf8dec_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CpW     = 21;
  localparam int unsigned CountW  = 3;
  localparam int unsigned BufLen  = 4;

  localparam logic [CpW-1:0] ReplacementChar = CpW'(24'h00FFFD);

  // continuation prefix 10xxxxxx
  localparam logic [1:0] ContTag = 2'b10;

  typedef logic [BufLen-1:0][ByteW-1:0] buf_t;

  // one decode step taken from the front of the buffer
  typedef struct packed {
    logic              produce;
    logic              bad;
    logic [CpW-1:0]    value;
    logic [CountW-1:0] used;
  } step_t;

  // controller to datapath
  typedef struct packed {
    logic advance;
    logic accept;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic produce;
    logic last;
    logic out_free;
  } dp_status_t;

  // decode the sequence at the front of bytes, which holds n valid bytes
  function automatic step_t decode_step(input buf_t bytes, input logic [CountW-1:0] n,
                                        input logic eos);
    step_t             s;
    logic [CountW-1:0] len;
    logic [CountW-1:0] avail;
    logic              bad;
    logic              brk;
    logic [ByteW-1:0]  b0;
    b0 = bytes[0];
    len = '0;
    if (!b0[7]) begin
      len = CountW'(1);
    end else if (!b0[6]) begin
      len = '0;
    end else if (!b0[5]) begin
      len = CountW'(2);
    end else if (!b0[4]) begin
      len = CountW'(3);
    end else if (!b0[3]) begin
      len = CountW'(4);
    end
    bad = (len == '0);
    avail = (n < len) ? n : len;
    for (int i = 1; i < BufLen; i++) begin
      if ((CountW'(i) < avail) && (bytes[i][7:6] != ContTag)) begin
        bad = 1'b1;
      end
    end
    brk = 1'b0;
    if (!bad && (n < len)) begin
      if (eos) begin
        bad = 1'b1;
      end else begin
        brk = 1'b1;
      end
    end
    s.produce = (n != '0) && !brk;
    s.bad     = bad;
    case (len)
      CountW'(2): s.value = CpW'({b0[4:0], bytes[1][5:0]});
      CountW'(3): s.value = CpW'({b0[3:0], bytes[1][5:0], bytes[2][5:0]});
      CountW'(4): s.value = {b0[2:0], bytes[1][5:0], bytes[2][5:0], bytes[3][5:0]};
      default:    s.value = CpW'(b0[6:0]);
    endcase
    if (bad) begin
      s.value = ReplacementChar;
      s.used  = CountW'(1);
    end else begin
      s.used  = len;
    end
    return s;
  endfunction

endpackage

// ===== rtl/core/utf8dec_in_if.sv =====
interface utf8dec_in_if;
  import utf8dec_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// ===== rtl/core/utf8dec_out_if.sv =====
interface utf8dec_out_if;
  import utf8dec_pkg::*;

  logic              valid;
  logic              ready;
  logic [CpW-1:0]    code_point;
  logic [CountW-1:0] byte_count;
  logic              replaced;
  logic              run_last;
  logic              stream_done;

  modport source (output valid, output code_point, output byte_count, output replaced,
                  output run_last, output stream_done, input ready);
  modport sink   (input valid, input code_point, input byte_count, input replaced,
                  input run_last, input stream_done, output ready);
endinterface

// ===== rtl/core/utf8dec_ctrl.sv =====
module utf8dec_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  utf8dec_pkg::dp_status_t status_i,
  output utf8dec_pkg::dp_cmd_t    cmd_o
);
  import utf8dec_pkg::*;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   running;
  logic   done_now;

  // release one result per cycle while the output register can take it
  assign running      = (state_q == StRun);
  assign cmd_o.advance = running && status_i.produce && status_i.out_free;

  // free for a new request once this byte releases nothing more
  assign done_now     = !running || !status_i.produce || (cmd_o.advance && status_i.last);
  assign in_ready_o   = done_now;
  assign cmd_o.accept = in_valid_i && done_now;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (cmd_o.accept) state_d = StRun;
      end
      StRun: begin
        if (cmd_o.accept) begin
          state_d = StRun;
        end else if (done_now) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/utf8dec_dp.sv =====
module utf8dec_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [utf8dec_pkg::ByteW-1:0]    data_byte_i,
  input  logic                             end_of_stream_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [utf8dec_pkg::CpW-1:0]      code_point_o,
  output logic [utf8dec_pkg::CountW-1:0]   byte_count_o,
  output logic                             replaced_o,
  output logic                             run_last_o,
  output logic                             stream_done_o,
  input  utf8dec_pkg::dp_cmd_t             cmd_i,
  output utf8dec_pkg::dp_status_t          status_o
);
  import utf8dec_pkg::*;

  buf_t              buf_q, buf_d;
  buf_t              shifted;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [CountW-1:0] rem_cnt;
  logic              eos_q, eos_d;
  logic              out_valid_q;
  step_t             step_cur;
  step_t             step_nxt;
  buf_t              base_buf;
  logic [CountW-1:0] base_cnt;

  // decode at the front, and look ahead one step past it
  assign step_cur = decode_step(buf_q, cnt_q, eos_q);
  assign rem_cnt  = cnt_q - step_cur.used;

  always_comb begin
    shifted = buf_q;
    case (step_cur.used)
      CountW'(1): shifted = {buf_q[3], buf_q[3:1]};
      CountW'(2): shifted = {buf_q[3:2], buf_q[3:2]};
      CountW'(3): shifted = {buf_q[3], buf_q[3], buf_q[3], buf_q[3]};
      default:    shifted = buf_q;
    endcase
  end

  assign step_nxt = decode_step(shifted, rem_cnt, eos_q);

  assign status_o.produce  = step_cur.produce;
  assign status_o.last     = !step_nxt.produce;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // buffer update: drop the consumed bytes, then append the new byte
  always_comb begin
    base_buf = cmd_i.advance ? shifted : buf_q;
    base_cnt = cmd_i.advance ? rem_cnt : cnt_q;
    buf_d    = base_buf;
    cnt_d    = base_cnt;
    eos_d    = eos_q;
    if (cmd_i.accept) begin
      buf_d[base_cnt[1:0]] = data_byte_i;
      cnt_d                = base_cnt + CountW'(1);
      eos_d                = end_of_stream_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      eos_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      eos_q <= eos_d;
      if (cmd_i.advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // buffer bytes and result payload
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    if (cmd_i.advance) begin
      code_point_o  <= step_cur.value;
      byte_count_o  <= step_cur.used;
      replaced_o    <= step_cur.bad;
      run_last_o    <= !step_nxt.produce;
      stream_done_o <= !step_nxt.produce && eos_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/utf8_decoder_with_replacement.sv =====
// channel  dir  handshake      payload
// in_i     in   valid/ready    data_byte[7:0], end_of_stream
// out_o    out  valid/ready    code_point[20:0], byte_count[2:0], replaced,
//                              run_last, stream_done
//
// A byte whose request completes with nothing else queued goes into the byte buffer;
// each result it releases is set by the single front-of-buffer decode step and is
// registered in the output register. Well-formed text runs at one byte per cycle
// while the output is not stalled; the next request is taken with the last result.
// Reset clears the byte count and the output valid; buffered bytes need no reset.
// A stalled output holds the decoder and, through it, the input.
module utf8_decoder_with_replacement (
  input logic           clk_i,
  input logic           rst_ni,
  utf8dec_in_if.sink    in_i,
  utf8dec_out_if.source out_o
);
  import utf8dec_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencing
  utf8dec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // byte buffer, decoder and output register
  utf8dec_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .data_byte_i     (in_i.data_byte),
    .end_of_stream_i (in_i.end_of_stream),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .code_point_o    (out_o.code_point),
    .byte_count_o    (out_o.byte_count),
    .replaced_o      (out_o.replaced),
    .run_last_o      (out_o.run_last),
    .stream_done_o   (out_o.stream_done),
    .cmd_i           (cmd),
    .status_o        (status)
  );

  // end of stream always closes the run of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.stream_done |-> out_o.run_last)
    else $error("stream_done without run_last");

  // a replacement consumes exactly one byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.replaced |->
      (out_o.code_point == ReplacementChar) && (out_o.byte_count == CountW'(1)))
    else $error("bad replacement result");

  // consumed byte count stays within one to four
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.byte_count != '0) && (out_o.byte_count <= CountW'(4)))
    else $error("byte_count out of range");

  // a new request is never taken while a result is being released and held back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |-> !(status.produce && !status.out_free && !in_i.ready) && in_i.valid)
    else $error("request taken while busy");

endmodule

// ===== dv/tb_utf8_decoder_with_replacement.sv =====
module tb_utf8_decoder_with_replacement;
  import utf8dec_pkg::*;

  localparam int unsigned QuietLimit  = 1000;
  localparam int unsigned RandomBytes = 380;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned NumRows     = 29;
  localparam int unsigned MaxPerByte  = 4;

  // lead byte prefixes of the multi-byte forms and the continuation prefix
  localparam logic [ByteW-1:0] Lead2    = 8'hC0;
  localparam logic [ByteW-1:0] Lead3    = 8'hE0;
  localparam logic [ByteW-1:0] Lead4    = 8'hF0;
  localparam logic [ByteW-1:0] ContBase = 8'h80;

  typedef struct packed {
    logic [CpW-1:0]    code_point;
    logic [CountW-1:0] byte_count;
    logic              replaced;
    logic              run_last;
    logic              stream_done;
  } decoded_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             eos;
  } stim_t;

  typedef struct packed {
    stim_t    req;
    logic     typed;
    decoded_t res;
  } row_t;

  // directed requests; typed rows carry the single result they must give
  localparam row_t Rows [NumRows] = '{
    // ascii extremes and bad lead bytes
    '{'{8'h00, 1'b0}, 1'b1, '{21'h000000, 3'd1, 1'b0, 1'b1, 1'b0}},
    '{'{8'h7F, 1'b0}, 1'b1, '{21'h00007F, 3'd1, 1'b0, 1'b1, 1'b0}},
    '{'{8'h80, 1'b0}, 1'b1, '{ReplacementChar, 3'd1, 1'b1, 1'b1, 1'b0}},
    '{'{8'hFF, 1'b0}, 1'b1, '{ReplacementChar, 3'd1, 1'b1, 1'b1, 1'b0}},
    '{'{8'hF8, 1'b0}, 1'b1, '{ReplacementChar, 3'd1, 1'b1, 1'b1, 1'b0}},
    // two and three byte forms
    '{'{8'hC2, 1'b0}, 1'b0, '0},
    '{'{8'hA9, 1'b0}, 1'b0, '0},
    '{'{8'hE2, 1'b0}, 1'b0, '0},
    '{'{8'h82, 1'b0}, 1'b0, '0},
    '{'{8'hAC, 1'b0}, 1'b0, '0},
    // largest four byte value
    '{'{8'hF7, 1'b0}, 1'b0, '0},
    '{'{8'hBF, 1'b0}, 1'b0, '0},
    '{'{8'hBF, 1'b0}, 1'b0, '0},
    '{'{8'hBF, 1'b0}, 1'b1, '{21'h1FFFFF, 3'd4, 1'b0, 1'b1, 1'b0}},
    // overlong zero passes through
    '{'{8'hC0, 1'b0}, 1'b0, '0},
    '{'{8'h80, 1'b0}, 1'b1, '{21'h000000, 3'd2, 1'b0, 1'b1, 1'b0}},
    // surrogate passes through
    '{'{8'hED, 1'b0}, 1'b0, '0},
    '{'{8'hA0, 1'b0}, 1'b0, '0},
    '{'{8'h80, 1'b0}, 1'b0, '0},
    // bad continuation, lead replaced and ascii re-examined
    '{'{8'hE2, 1'b0}, 1'b0, '0},
    '{'{8'h41, 1'b0}, 1'b0, '0},
    // bad fourth byte releases four results
    '{'{8'hF0, 1'b0}, 1'b0, '0},
    '{'{8'h90, 1'b0}, 1'b0, '0},
    '{'{8'h80, 1'b0}, 1'b0, '0},
    '{'{8'h41, 1'b0}, 1'b0, '0},
    // sequence cut off at stream end
    '{'{8'hF0, 1'b0}, 1'b0, '0},
    '{'{8'h90, 1'b0}, 1'b0, '0},
    '{'{8'h80, 1'b1}, 1'b0, '0},
    // single byte stream
    '{'{8'h41, 1'b1}, 1'b1, '{21'h000041, 3'd1, 1'b0, 1'b1, 1'b1}}
  };

  logic clk_i;
  logic rst_ni;

  utf8dec_in_if  in_if ();
  utf8dec_out_if out_if ();

  utf8_decoder_with_replacement DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // decoder state mirror
  logic [ByteW-1:0] held_bytes [3];
  int               held_count;

  decoded_t    chars_due [$];
  stim_t       byte_plan [$];
  decoded_t    want;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int          mismatches   = 0;
  int unsigned quiet_cycles = 0;

  always #2 clk_i = ~clk_i;

  // decode one accepted byte against the held bytes, giving its results
  task automatic decode_byte(input stim_t s, output decoded_t outs [$]);
    logic [ByteW-1:0] q [$];
    logic [ByteW-1:0] lead;
    logic [CpW-1:0]   val;
    logic             bad;
    decoded_t         r;
    int               len;
    int               used;
    int               k;
    outs = {};
    for (k = 0; k < held_count; k++) q.push_back(held_bytes[k]);
    q.push_back(s.data);
    while (q.size() > 0 && outs.size() < MaxPerByte) begin
      lead = q[0];
      if (!lead[7]) begin
        len = 1;
        val = CpW'(lead[6:0]);
      end else if (!lead[6]) begin
        len = 0;
        val = '0;
      end else if (!lead[5]) begin
        len = 2;
        val = CpW'(lead[4:0]);
      end else if (!lead[4]) begin
        len = 3;
        val = CpW'(lead[3:0]);
      end else if (!lead[3]) begin
        len = 4;
        val = CpW'(lead[2:0]);
      end else begin
        len = 0;
        val = '0;
      end
      bad = (len == 0);
      for (k = 1; k < len && k < q.size(); k++) begin
        if (q[k][7:6] != ContTag) bad = 1'b1;
      end
      // incomplete: wait for more bytes unless the stream ends here
      if (!bad && q.size() < len) begin
        if (!s.eos) break;
        bad = 1'b1;
      end
      if (bad) begin
        val  = ReplacementChar;
        used = 1;
      end else begin
        for (k = 1; k < len; k++) val = {val[CpW-7:0], q[k][5:0]};
        used = len;
      end
      r = '{val, CountW'(used), bad, 1'b0, 1'b0};
      outs.push_back(r);
      repeat (used) void'(q.pop_front());
    end
    if (outs.size() > 0) begin
      outs[outs.size()-1].run_last    = 1'b1;
      outs[outs.size()-1].stream_done = s.eos;
    end
    held_count = q.size();
    for (k = 0; k < q.size(); k++) held_bytes[k] = q[k];
  endtask

  // present one request, wait for its handshake, then log what it must give
  task automatic send_request(input stim_t s, input logic typed, input decoded_t typed_res);
    decoded_t outs [$];
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.data_byte     <= s.data;
    in_if.end_of_stream <= s.eos;
    do @(posedge clk_i); while (!in_if.ready);
    decode_byte(s, outs);
    if (typed) begin
      chars_due.push_back(typed_res);
    end else begin
      foreach (outs[i]) chars_due.push_back(outs[i]);
    end
    @(negedge clk_i);
  endtask

  // hold off requests until every pending result has come out
  task automatic drain_pause();
    in_if.valid <= 1'b0;
    while (chars_due.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // random text: mostly well-formed sequences, some cut short, some raw noise
  task automatic plan_random();
    logic [ByteW-1:0] seq [$];
    logic [ByteW-1:0] lead;
    stim_t            s;
    int               kind;
    int               len;
    int               conts;
    while (byte_plan.size() < RandomBytes) begin
      seq  = {};
      kind = $urandom_range(99);
      if (kind < 30) begin
        seq.push_back(ByteW'($urandom_range(127)));
      end else if (kind < 88) begin
        if (kind < 50) len = 2;
        else if (kind < 65) len = 3;
        else if (kind < 78) len = 4;
        else len = $urandom_range(4, 2);
        conts = (kind < 78) ? len - 1 : $urandom_range(len - 2);
        case (len)
          2: lead = Lead2 | ByteW'($urandom_range(31));
          3: lead = Lead3 | ByteW'($urandom_range(15));
          default: lead = Lead4 | ByteW'($urandom_range(7));
        endcase
        seq.push_back(lead);
        repeat (conts) seq.push_back(ContBase | ByteW'($urandom_range(63)));
      end else begin
        seq.push_back(ByteW'($urandom()));
      end
      foreach (seq[k]) begin
        s.data = seq[k];
        s.eos  = (k == seq.size() - 1 && $urandom_range(11) == 0) ||
                 ($urandom_range(49) == 0);
        byte_plan.push_back(s);
      end
    end
  endtask

  // receiver stalls
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // compare each accepted result with the oldest expected one
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (chars_due.size() == 0) begin
        $error("unexpected result: code_point %h", out_if.code_point);
        mismatches++;
      end else begin
        want = chars_due.pop_front();
        if (out_if.code_point !== want.code_point) begin
          $error("code_point: expected %h, got %h", want.code_point, out_if.code_point);
          mismatches++;
        end
        if (out_if.byte_count !== want.byte_count) begin
          $error("byte_count: expected %0d, got %0d", want.byte_count, out_if.byte_count);
          mismatches++;
        end
        if (out_if.replaced !== want.replaced) begin
          $error("replaced: expected %b, got %b", want.replaced, out_if.replaced);
          mismatches++;
        end
        if (out_if.run_last !== want.run_last) begin
          $error("run_last: expected %b, got %b", want.run_last, out_if.run_last);
          mismatches++;
        end
        if (out_if.stream_done !== want.stream_done) begin
          $error("stream_done: expected %b, got %b", want.stream_done, out_if.stream_done);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QuietLimit) begin
      $display("[utf8_decoder_with_replacement] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // reset, directed table, then four random phases of idling and output stalls
  initial begin
    int phase;
    int idx;
    int n;
    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.data_byte     = '0;
    in_if.end_of_stream = 1'b0;
    out_if.ready        = 1'b0;
    idle_pct            = 0;
    stall_pct           = 0;
    held_count          = 0;
    foreach (held_bytes[k]) held_bytes[k] = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (Rows[i]) send_request(Rows[i].req, Rows[i].typed, Rows[i].res);

    plan_random();
    n = byte_plan.size();
    for (phase = 0; phase < 4; phase++) begin
      drain_pause();
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      for (idx = phase * n / 4; idx < (phase + 1) * n / 4; idx++) begin
        send_request(byte_plan[idx], 1'b0, '0);
      end
    end

    drain_pause();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[utf8_decoder_with_replacement] OK");
    end else begin
      $display("[utf8_decoder_with_replacement] ERROR");
    end
    $finish;
  end

endmodule
